@@ src/debounced_led_pattern_sequencer_unit_assert.svh @@
// assertion macros for the led pattern sequencer
// depends on clk_i and rst_ni in the including module
`ifndef DEBOUNCED_LED_PATTERN_SEQUENCER_UNIT_ASSERT_SVH
`define DEBOUNCED_LED_PATTERN_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication
`define DLPS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dlps assertion failed");

// next-cycle implication
`define DLPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dlps assertion failed");

`endif

@@ src/dlps_pkg.sv @@
// shared types, codes and constants of the led pattern sequencer
// no dependencies
package dlps_pkg;

  localparam int unsigned ADDR_W = 5;

  localparam logic [15:0] CLOCK_STEP = 16'd2;
  localparam logic [7:0]  FRACT_STEP = 8'd6;
  localparam logic [7:0]  FRACT_WRAP = 8'd125;
  localparam logic [7:0]  FULL_LEVEL = 8'd255;

  localparam logic [7:0]  THRESH_RST     = 8'd20;
  localparam logic [15:0] BLINK_MS_RST   = 16'd1000;
  localparam logic [15:0] FADE_RAMP_RST  = 16'd350;
  localparam logic [15:0] FADE_HOLD_RST  = 16'd300;

  // fade phase codes
  localparam logic [2:0] FP_UP_ONE    = 3'd0;
  localparam logic [2:0] FP_HOLD_ONE  = 3'd1;
  localparam logic [2:0] FP_DOWN_ONE  = 3'd2;
  localparam logic [2:0] FP_UP_TWO    = 3'd3;
  localparam logic [2:0] FP_HOLD_TWO  = 3'd4;
  localparam logic [2:0] FP_DOWN_TWO  = 3'd5;

  typedef enum logic [1:0] {
    MODE_DARK,
    MODE_ON,
    MODE_BLINK,
    MODE_FADE
  } mode_e;

  typedef enum logic [2:0] {
    REG_THRESH,
    REG_BLINK_FIRST,
    REG_BLINK_SECOND,
    REG_FADE_UP,
    REG_FADE_HOLD,
    REG_FADE_DOWN
  } reg_idx_e;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_e;

  typedef struct packed {
    logic [7:0]  thresh;
    logic [15:0] blink_first;
    logic [15:0] blink_second;
    logic [15:0] fade_up;
    logic [15:0] fade_hold;
    logic [15:0] fade_down;
  } cfg_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic [7:0] quot;
    logic       rem_nz;
  } div_res_t;

  // length of a fade phase, unused codes fall back to the ramp up length
  function automatic logic [15:0] fade_len(input logic [2:0] ph, input cfg_t cfg);
    logic [15:0] len;
    case (ph) inside
      FP_HOLD_ONE, FP_HOLD_TWO: len = cfg.fade_hold;
      FP_DOWN_ONE, FP_DOWN_TWO: len = cfg.fade_down;
      default:                  len = cfg.fade_up;
    endcase
    return len;
  endfunction

endpackage

@@ src/debounced_led_pattern_sequencer_unit.sv @@
// result: registered from the input beat and valid in the cycle after it, on fading ramp ticks
//   once the divider is done; one beat per cycle outside fading ramps while results are taken,
//   on ramps no new beat until the eight step restoring divider has formed the ramp level
// reset: asynchronous active low, clears the clock, debounce and led state,
//   mode starts in fading, registers take their documented defaults
`include "debounced_led_pattern_sequencer_unit_assert.svh"

module debounced_led_pattern_sequencer_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dlps_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        button_down_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  led_one_level_o,
  output logic [7:0]                  led_two_level_o,
  output logic [1:0]                  current_mode_o,
  output logic                        button_latched_o
);
  import dlps_pkg::*;

  cfg_t     cfg;
  div_res_t div_res;

  state_e      state_q, state_d;
  logic [15:0] millis_q, millis_d;
  logic [6:0]  frac_q, frac_d;
  logic [7:0]  press_q, press_d, release_q, release_d;
  logic        pressed_q, pressed_d;
  mode_e       mode_q, mode_d;
  logic        blink_q, blink_d;
  logic [2:0]  fade_q, fade_d;
  logic [15:0] pstart_q, pstart_d;
  logic [7:0]  led_one_q, led_one_d, led_two_q, led_two_d;
  logic        out_valid_q;

  logic        in_fire, out_fire, need_div, div_start;
  logic [7:0]  fr_sum, press_inc, release_inc;
  logic [15:0] elapsed, e_use, len;
  logic [23:0] num;
  logic [8:0]  ceil_q;
  logic [7:0]  down_level;

  dlps_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_q && out_ready_i;

  // tick: clock, debounce, mode and led update
  always_comb begin
    fr_sum      = {1'b0, frac_q} + FRACT_STEP;
    millis_d    = millis_q + CLOCK_STEP;
    frac_d      = fr_sum[6:0];
    if (fr_sum >= FRACT_WRAP) begin
      frac_d   = 7'(fr_sum - FRACT_WRAP);
      millis_d = millis_q + CLOCK_STEP + 16'd1;
    end

    press_inc   = (press_q == 8'hFF) ? press_q : press_q + 8'd1;
    release_inc = (release_q == 8'hFF) ? release_q : release_q + 8'd1;
    press_d     = press_q;
    release_d   = release_q;
    pressed_d   = pressed_q;
    mode_d      = mode_q;
    if (button_down_i) begin
      if (!pressed_q) begin
        press_d = press_inc;
        if (press_inc > cfg.thresh) begin
          pressed_d = 1'b1;
          mode_d    = mode_e'(mode_q + 2'd1);
        end
      end
      release_d = 8'd0;
    end else begin
      if (pressed_q) begin
        release_d = release_inc;
        if (release_inc > cfg.thresh) pressed_d = 1'b0;
      end
      press_d = 8'd0;
    end

    elapsed   = millis_d - pstart_q;
    e_use     = elapsed;
    len       = 16'd0;
    blink_d   = blink_q;
    fade_d    = fade_q;
    pstart_d  = pstart_q;
    led_one_d = led_one_q;
    led_two_d = led_two_q;
    need_div  = 1'b0;
    case (mode_d)
      MODE_DARK: begin
        led_one_d = 8'd0;
        led_two_d = 8'd0;
      end
      MODE_ON: begin
        led_one_d = FULL_LEVEL;
        led_two_d = FULL_LEVEL;
      end
      MODE_BLINK: begin
        len = blink_q ? cfg.blink_second : cfg.blink_first;
        if (elapsed >= len) begin
          pstart_d  = millis_d;
          blink_d   = !blink_q;
          led_one_d = blink_q ? 8'd0 : FULL_LEVEL;
          led_two_d = blink_q ? FULL_LEVEL : 8'd0;
        end
      end
      default: begin
        if (elapsed >= fade_len(fade_q, cfg)) begin
          pstart_d = millis_d;
          fade_d   = (fade_q >= FP_DOWN_TWO) ? FP_UP_ONE : fade_q + 3'd1;
          e_use    = 16'd0;
        end
        len       = fade_len(fade_d, cfg);
        led_one_d = 8'd0;
        led_two_d = 8'd0;
        case (fade_d)
          FP_UP_ONE: begin
            if (len == 16'd0) led_one_d = FULL_LEVEL;
            else need_div = 1'b1;
          end
          FP_HOLD_ONE: led_one_d = FULL_LEVEL;
          FP_DOWN_ONE: begin
            if (len != 16'd0) need_div = 1'b1;
          end
          FP_UP_TWO: begin
            if (len == 16'd0) led_two_d = FULL_LEVEL;
            else need_div = 1'b1;
          end
          FP_HOLD_TWO: led_two_d = FULL_LEVEL;
          FP_DOWN_TWO: begin
            if (len != 16'd0) need_div = 1'b1;
          end
          default: begin
            led_one_d = 8'd0;
            led_two_d = 8'd0;
          end
        endcase
      end
    endcase
  end

  // 255 * elapsed as shift and subtract
  assign num = {e_use, 8'd0} - {8'd0, e_use};

  dlps_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (len),
    .res_o   (div_res)
  );

  // ramp down level from the rounded up quotient
  assign ceil_q     = {1'b0, div_res.quot} + {8'd0, div_res.rem_nz};
  assign down_level = (ceil_q > {1'b0, FULL_LEVEL}) ? 8'd0 : FULL_LEVEL - ceil_q[7:0];

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire && need_div) state_d = ST_DIV;
      ST_DIV:  if (div_res.done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = !out_valid_q || out_ready_i;
        div_start  = in_fire && need_div;
      end
      ST_DIV:  in_ready_o = 1'b0;
      default: in_ready_o = 1'b0;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      millis_q    <= 16'd0;
      frac_q      <= 7'd0;
      press_q     <= 8'd0;
      release_q   <= 8'd0;
      pressed_q   <= 1'b0;
      mode_q      <= MODE_FADE;
      blink_q     <= 1'b0;
      fade_q      <= FP_UP_ONE;
      pstart_q    <= 16'd0;
      led_one_q   <= 8'd0;
      led_two_q   <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        millis_q    <= millis_d;
        frac_q      <= frac_d;
        press_q     <= press_d;
        release_q   <= release_d;
        pressed_q   <= pressed_d;
        mode_q      <= mode_d;
        blink_q     <= blink_d;
        fade_q      <= fade_d;
        pstart_q    <= pstart_d;
        led_one_q   <= led_one_d;
        led_two_q   <= led_two_d;
        out_valid_q <= !need_div;
      end else if (state_q == ST_DIV && div_res.done) begin
        case (fade_q)
          FP_UP_ONE:   led_one_q <= div_res.quot;
          FP_DOWN_ONE: led_one_q <= down_level;
          FP_UP_TWO:   led_two_q <= div_res.quot;
          FP_DOWN_TWO: led_two_q <= down_level;
          default:     led_one_q <= led_one_q;
        endcase
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign led_one_level_o  = led_one_q;
  assign led_two_level_o  = led_two_q;
  assign current_mode_o   = mode_q;
  assign button_latched_o = pressed_q;

  // divider idles whenever a new beat can be taken
  `DLPS_ASSERT_IMPL(a_ready_div_idle, in_ready_o, !div_res.busy)
  // divider completion only lands while the sequencer waits for it
  `DLPS_ASSERT_IMPL(a_done_in_div, div_res.done, state_q == ST_DIV)
  // ticks that need no division give their result directly, without the divider
  `DLPS_ASSERT_NEXT(a_direct_result, in_fire && !need_div, out_valid_o && state_q == ST_IDLE)
  // fade phase never leaves its six codes
  `DLPS_ASSERT_IMPL(a_fade_phase_range, 1'b1, fade_q != 3'd6 && fade_q != 3'd7)

endmodule

@@ src/dlps_regs.sv @@
// apb configuration registers of the led pattern sequencer
// depends on dlps_pkg
module dlps_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dlps_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output dlps_pkg::cfg_t              cfg_o
);
  import dlps_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_THRESH:       cfg_d.thresh       = pwdata[7:0];
        REG_BLINK_FIRST:  cfg_d.blink_first  = pwdata[15:0];
        REG_BLINK_SECOND: cfg_d.blink_second = pwdata[15:0];
        REG_FADE_UP:      cfg_d.fade_up      = pwdata[15:0];
        REG_FADE_HOLD:    cfg_d.fade_hold    = pwdata[15:0];
        REG_FADE_DOWN:    cfg_d.fade_down    = pwdata[15:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thresh       <= THRESH_RST;
      cfg_q.blink_first  <= BLINK_MS_RST;
      cfg_q.blink_second <= BLINK_MS_RST;
      cfg_q.fade_up      <= FADE_RAMP_RST;
      cfg_q.fade_hold    <= FADE_HOLD_RST;
      cfg_q.fade_down    <= FADE_RAMP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_THRESH:       prdata = {24'd0, cfg_q.thresh};
      REG_BLINK_FIRST:  prdata = {16'd0, cfg_q.blink_first};
      REG_BLINK_SECOND: prdata = {16'd0, cfg_q.blink_second};
      REG_FADE_UP:      prdata = {16'd0, cfg_q.fade_up};
      REG_FADE_HOLD:    prdata = {16'd0, cfg_q.fade_hold};
      REG_FADE_DOWN:    prdata = {16'd0, cfg_q.fade_down};
      default:          prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/dlps_div.sv @@
// restoring divider, one quotient bit per cycle, eight bit quotient
// depends on dlps_pkg; numerator must stay below 256 times the divisor
module dlps_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [23:0]        num_i,
  input  logic [15:0]        den_i,
  output dlps_pkg::div_res_t res_o
);
  import dlps_pkg::*;

  logic [15:0] rem_q, den_q;
  logic [7:0]  low_q, quot_q;
  logic [2:0]  cnt_q;
  logic        busy_q, done_q;
  logic [16:0] trial, diff;
  logic        ge;

  // one shift and trial subtract
  assign trial = {rem_q, low_q[7]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 3'd7;
      end else if (busy_q) begin
        if (cnt_q == 3'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 3'd1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i[23:8];
      low_q  <= num_i[7:0];
      den_q  <= den_i;
      quot_q <= 8'd0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[15:0] : trial[15:0];
      low_q  <= {low_q[6:0], 1'b0};
      quot_q <= {quot_q[6:0], ge};
    end
  end

  assign res_o.busy   = busy_q;
  assign res_o.done   = done_q;
  assign res_o.quot   = quot_q;
  assign res_o.rem_nz = rem_q != 16'd0;

endmodule

@@ verif/debounced_led_pattern_sequencer_unit_tb.sv @@
`timescale 1ns / 100ps
// testbench of the led pattern sequencer: a scoreboard class predicts each tick
// and checks every result beat; depends on dlps_pkg and the unit under src

import dlps_pkg::*;

typedef struct {
  logic [7:0] led_one;
  logic [7:0] led_two;
  mode_e      mode;
  logic       latched;
} led_levels_t;

class led_level_scoreboard;
  cfg_t        cfg;
  logic [15:0] millis;
  logic [7:0]  frac;
  logic [7:0]  press_cnt;
  logic [7:0]  rel_cnt;
  logic        pressed;
  mode_e       mode;
  logic        blink_ph;
  logic [2:0]  fade_ph;
  logic [15:0] phase_start;
  logic [7:0]  led_one;
  logic [7:0]  led_two;
  led_levels_t expected_levels[$];
  int          level_mismatches;

  function void reset_state();
    cfg.thresh       = THRESH_RST;
    cfg.blink_first  = BLINK_MS_RST;
    cfg.blink_second = BLINK_MS_RST;
    cfg.fade_up      = FADE_RAMP_RST;
    cfg.fade_hold    = FADE_HOLD_RST;
    cfg.fade_down    = FADE_RAMP_RST;
    millis      = '0;
    frac        = '0;
    press_cnt   = '0;
    rel_cnt     = '0;
    pressed     = 1'b0;
    mode        = MODE_FADE;
    blink_ph    = 1'b0;
    fade_ph     = FP_UP_ONE;
    phase_start = '0;
    led_one     = '0;
    led_two     = '0;
    level_mismatches = 0;
    expected_levels.delete();
  endfunction

  function void write_reg(reg_idx_e idx, logic [31:0] value);
    case (idx)
      REG_THRESH:       cfg.thresh       = value[7:0];
      REG_BLINK_FIRST:  cfg.blink_first  = value[15:0];
      REG_BLINK_SECOND: cfg.blink_second = value[15:0];
      REG_FADE_UP:      cfg.fade_up      = value[15:0];
      REG_FADE_HOLD:    cfg.fade_hold    = value[15:0];
      REG_FADE_DOWN:    cfg.fade_down    = value[15:0];
      default: ;
    endcase
  endfunction

  function logic [15:0] phase_length(logic [2:0] ph);
    logic [15:0] len;
    if (ph == FP_HOLD_ONE || ph == FP_HOLD_TWO) len = cfg.fade_hold;
    else if (ph == FP_DOWN_ONE || ph == FP_DOWN_TWO) len = cfg.fade_down;
    else len = cfg.fade_up;
    return len;
  endfunction

  // floor of 255*e/d, saturated
  function logic [7:0] ramp_rise(logic [15:0] e, logic [15:0] d);
    logic [31:0] q;
    if (d == 16'd0) return FULL_LEVEL;
    q = (32'd255 * e) / d;
    return (q > 32'd255) ? FULL_LEVEL : q[7:0];
  endfunction

  // 255 minus the ceiling of 255*e/d, saturated
  function logic [7:0] ramp_fall(logic [15:0] e, logic [15:0] d);
    logic [31:0] q;
    if (d == 16'd0) return 8'd0;
    q = (32'd255 * e + d - 32'd1) / d;
    return (q > 32'd255) ? 8'd0 : 8'(32'd255 - q);
  endfunction

  // one accepted tick: advance the model and queue the expected levels
  function void note_tick(logic down);
    logic [8:0]  fr;
    logic [15:0] elapsed;
    logic [15:0] len;
    led_levels_t lv;
    // millisecond clock with fractional carry
    millis = millis + CLOCK_STEP;
    fr = 9'(frac) + 9'(FRACT_STEP);
    if (fr >= 9'(FRACT_WRAP)) begin
      fr = fr - 9'(FRACT_WRAP);
      millis = millis + 16'd1;
    end
    frac = fr[7:0];
    // debounce
    if (down) begin
      if (!pressed) begin
        if (press_cnt != 8'hff) press_cnt = press_cnt + 8'd1;
        if (press_cnt > cfg.thresh) begin
          pressed = 1'b1;
          mode = mode_e'(2'(mode + 2'd1));
        end
      end
      rel_cnt = '0;
    end else begin
      if (pressed) begin
        if (rel_cnt != 8'hff) rel_cnt = rel_cnt + 8'd1;
        if (rel_cnt > cfg.thresh) pressed = 1'b0;
      end
      press_cnt = '0;
    end
    // led levels
    elapsed = millis - phase_start;
    case (mode)
      MODE_DARK: begin
        led_one = '0;
        led_two = '0;
      end
      MODE_ON: begin
        led_one = FULL_LEVEL;
        led_two = FULL_LEVEL;
      end
      MODE_BLINK: begin
        len = blink_ph ? cfg.blink_second : cfg.blink_first;
        if (elapsed >= len) begin
          phase_start = millis;
          if (!blink_ph) begin
            led_one = FULL_LEVEL;
            led_two = '0;
            blink_ph = 1'b1;
          end else begin
            led_one = '0;
            led_two = FULL_LEVEL;
            blink_ph = 1'b0;
          end
        end
      end
      default: begin
        if (elapsed >= phase_length(fade_ph)) begin
          phase_start = millis;
          fade_ph = (fade_ph >= FP_DOWN_TWO) ? FP_UP_ONE : fade_ph + 3'd1;
          elapsed = '0;
        end
        len = phase_length(fade_ph);
        led_one = '0;
        led_two = '0;
        case (fade_ph)
          FP_UP_ONE:   led_one = ramp_rise(elapsed, len);
          FP_HOLD_ONE: led_one = FULL_LEVEL;
          FP_DOWN_ONE: led_one = ramp_fall(elapsed, len);
          FP_UP_TWO:   led_two = ramp_rise(elapsed, len);
          FP_HOLD_TWO: led_two = FULL_LEVEL;
          FP_DOWN_TWO: led_two = ramp_fall(elapsed, len);
          default: ;
        endcase
      end
    endcase
    lv.led_one = led_one;
    lv.led_two = led_two;
    lv.mode    = mode;
    lv.latched = pressed;
    expected_levels.push_back(lv);
  endfunction

  // compare one result beat with the oldest expectation
  function void check_levels(led_levels_t got);
    led_levels_t want;
    if (expected_levels.size() == 0) begin
      if (level_mismatches < 10)
        $display("%0t: result beat with nothing expected: ", $time,
                 "led1=%0d led2=%0d mode=%0d btn=%0b",
                 got.led_one, got.led_two, got.mode, got.latched);
      level_mismatches++;
      return;
    end
    want = expected_levels.pop_front();
    if (got.led_one !== want.led_one || got.led_two !== want.led_two ||
        got.mode !== want.mode || got.latched !== want.latched) begin
      if (level_mismatches < 10)
        $display("%0t: mismatch exp led1=%0d led2=%0d mode=%0d btn=%0b",
                 $time, want.led_one, want.led_two, want.mode, want.latched,
                 " got led1=%0d led2=%0d mode=%0d btn=%0b",
                 got.led_one, got.led_two, got.mode, got.latched);
      level_mismatches++;
    end
  endfunction

  function int pending();
    return expected_levels.size();
  endfunction
endclass

module debounced_led_pattern_sequencer_unit_tb;

  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_TICKS = 950;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                button_down_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [7:0]          led_one_level_o;
  logic [7:0]          led_two_level_o;
  logic [1:0]          current_mode_o;
  logic                button_latched_o;

  logic                steady_run;
  bit                  button_plan[$];
  int                  idle_cycles = 0;
  led_level_scoreboard sb;

  debounced_led_pattern_sequencer_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .button_down_i    (button_down_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .led_one_level_o  (led_one_level_o),
    .led_two_level_o  (led_two_level_o),
    .current_mode_o   (current_mode_o),
    .button_latched_o (button_latched_o)
  );

  always #10 clk_i = ~clk_i;

  // receiver side back pressure
  always @(posedge clk_i) begin
    out_ready_i <= steady_run ? 1'b1 : ($urandom_range(0, 99) >= 21);
  end

  // beat monitor, scoreboard hookup and stall watchdog
  always @(posedge clk_i) begin
    led_levels_t got;
    if (in_valid_i && in_ready_o) sb.note_tick(button_down_i);
    if (out_valid_o && out_ready_i) begin
      got.led_one = led_one_level_o;
      got.led_two = led_two_level_o;
      got.mode    = mode_e'(current_mode_o);
      got.latched = button_latched_o;
      sb.check_levels(got);
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // apb write: setup then access, then psel is dropped before the task returns
  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(int thr, int bf, int bs, int fu, int fh, int fd);
    write_reg(REG_THRESH, thr);
    write_reg(REG_BLINK_FIRST, bf);
    write_reg(REG_BLINK_SECOND, bs);
    write_reg(REG_FADE_UP, fu);
    write_reg(REG_FADE_HOLD, fh);
    write_reg(REG_FADE_DOWN, fd);
  endtask

  // send every planned button sample, idling at random unless steady
  task automatic drive_ticks();
    bit b;
    while (button_plan.size() != 0) begin
      b = button_plan.pop_front();
      while (!steady_run && $urandom_range(0, 99) < 21) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      in_valid_i    <= 1'b1;
      button_down_i <= b;
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
    end
    in_valid_i <= 1'b0;
  endtask

  // hold off until every result is back and the divider has settled
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // mostly clean press and release holds, some bounce and short holds
  task automatic plan_presses(int thr, int n);
    int r;
    int len;
    while (button_plan.size() < n) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        len = thr + 1 + $urandom_range(0, 4);
        repeat (len) button_plan.push_back(1'b1);
        len = thr + 1 + $urandom_range(0, 12);
        repeat (len) button_plan.push_back(1'b0);
      end else if (r < 90 || thr == 0) begin
        repeat ($urandom_range(1, 6)) button_plan.push_back($urandom_range(0, 1));
      end else begin
        repeat ($urandom_range(1, thr)) button_plan.push_back(1'b1);
        repeat ($urandom_range(1, thr)) button_plan.push_back(1'b0);
      end
    end
  endtask

  function automatic int pick_ms();
    int r;
    r = $urandom_range(0, 11);
    if (r == 0) return 65535;
    if (r == 1) return 1;
    return $urandom_range(2, 16);
  endfunction

  initial begin
    int random_ticks;
    int ph;
    int thr;
    sb = new();
    sb.reset_state();
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_valid_i    <= 1'b0;
    button_down_i <= 1'b0;
    out_ready_i   <= 1'b0;
    steady_run    <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset defaults in fading, then every mode with fast phases
    repeat (3) button_plan.push_back(1'b0);
    drive_ticks();
    wait_drained();
    write_all(0, 1, 2, 3, 1, 5);
    // press to off, on, blink, two swaps, fade through its phases, off, held press
    button_plan = {1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
                   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
    drive_ticks();
    wait_drained();

    // random phases, each with its own register setting
    random_ticks = 0;
    ph = 0;
    while (random_ticks < RANDOM_TICKS) begin
      if (ph == 0) begin
        thr = 0;
        write_all(thr, 1, 1, 1, 1, 1);
        plan_presses(thr, 60);
      end else if (ph == 1) begin
        // top threshold with long holds and no idling on either side
        thr = 254;
        write_all(thr, 65535, 65535, 65535, 65535, 65535);
        repeat (256) button_plan.push_back(1'b1);
        repeat (256) button_plan.push_back(1'b0);
        steady_run <= 1'b1;
      end else begin
        thr = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
        write_all(thr, pick_ms(), pick_ms(), pick_ms(), pick_ms(), pick_ms());
        plan_presses(thr, 60);
      end
      random_ticks += button_plan.size();
      drive_ticks();
      wait_drained();
      steady_run <= 1'b0;
      ph++;
    end

    wait_drained();
    if (sb.level_mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
